[hdl/tadc_pkg.sv]
`timescale 1ns / 1ps
package tadc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int SCALE       = 100;
   localparam int SAMPLE_BITS = 12;

   localparam int IDX_BITS   = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS   = IDX_BITS + 1;
   localparam int OFS_BITS   = 8;
   localparam int QUO_BITS   = $clog2(SCALE + 1);
   localparam int STEP_BITS  = $clog2(QUO_BITS);
   localparam int PROD_BITS  = SAMPLE_BITS + QUO_BITS;
   localparam int SCALED_W   = 15;
   localparam int CENTI_W    = 16;

   localparam logic ACT_WRITE   = 1'b0;
   localparam logic ACT_CONVERT = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [7:0]             entry_index;
      logic [SAMPLE_BITS-1:0] entry_value;
      logic [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SCALED_W-1:0]       temp_scaled;
      logic signed [CENTI_W-1:0] temp_centi;
   } rsp_type;

endpackage

[hdl/tadc_ram.sv]
`timescale 1ns / 1ps
module tadc_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/thermistor_adc_to_temperature_unit.sv]
`timescale 1ns / 1ps
// Channel    Ports                                   Direction
// request    start, busy, req_data                   in (busy is out)
// response   rsp_strobe, rsp_data                    out, one cycle, no stall
// csr        psel, penable, pwrite, paddr, pwdata,   APB, pready always high
//            prdata, pready
//
// A write beat loads one table entry; busy stays low.
// A convert beat holds busy through a clamp against the two table end reads,
// up to nine search steps on the single table read port, then, if needed, two
// bracket reads and seven restoring divide steps on one shared subtract unit.
// Active-high sync reset idles the sequencer, presets the csr; table is unset.
// Response strobe rises as busy falls, lasts one cycle, no hold-off.
module thermistor_adc_to_temperature_unit
   import tadc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_type       req_data,
   output logic          rsp_strobe,
   output rsp_type       rsp_data,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata,
   output logic          pready
);

   localparam logic REG_TABLE_COUNT = 1'b0;
   localparam logic REG_ZERO_OFFSET = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_FIRST, ST_RD_LAST, ST_CLAMP, ST_SRCH_RD, ST_SRCH_CMP,
      ST_RD_LO, ST_RD_HI, ST_CALC, ST_DIV, ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_BITS-1:0]          table_count_ff, table_count_in;
   logic [OFS_BITS-1:0]          zero_offset_ff, zero_offset_in;
   logic [SAMPLE_BITS-1:0]       s_ff, s_in;
   logic [SAMPLE_BITS-1:0]       first_ff, first_in;
   logic [SAMPLE_BITS-1:0]       tl_ff, tl_in;
   logic [IDX_BITS-1:0]          cnt_m1_ff, cnt_m1_in;
   logic signed [CNT_BITS:0]     left_ff, left_in, right_ff, right_in;
   logic [IDX_BITS-1:0]          lo_ff, lo_in, hi_ff, hi_in;
   logic [PROD_BITS-1:0]         rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]       div_ff, div_in;
   logic [QUO_BITS-1:0]          quo_ff, quo_in;
   logic [STEP_BITS-1:0]         step_ff, step_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   rsp_type                      rsp_ff, rsp_in;

   logic                         accept;
   logic                         csr_wr;
   logic [IDX_BITS-1:0]          rd_addr;
   logic [SAMPLE_BITS-1:0]       rd_data;
   logic signed [CNT_BITS:0]     mid_sum;
   logic [IDX_BITS-1:0]          mid;
   logic signed [CNT_BITS:0]     mid_wide;
   logic signed [CNT_BITS:0]     next_left, next_right;
   logic signed [SAMPLE_BITS:0]  diff;
   logic [SAMPLE_BITS-1:0]       num;
   logic [PROD_BITS-1:0]         trial;
   logic [SCALED_W-1:0]          scaled;

   assign accept = start && !busy;
   assign csr_wr = psel && penable && pwrite && pready;
   assign busy   = (state_ff != ST_IDLE);
   assign pready = 1'b1;

   always_comb begin
      prdata = 32'd0;
      unique case (paddr[2])
         REG_TABLE_COUNT: prdata = 32'(table_count_ff);
         REG_ZERO_OFFSET: prdata = 32'(zero_offset_ff);
         default:         prdata = 32'd0;
      endcase
   end

   assign mid_sum    = left_ff + right_ff;
   assign mid        = mid_sum[IDX_BITS:1];
   assign mid_wide   = (CNT_BITS+1)'(mid);
   assign next_left  = mid_wide + (CNT_BITS+1)'(1);
   assign next_right = mid_wide - (CNT_BITS+1)'(1);
   assign diff       = (SAMPLE_BITS+1)'(tl_ff) - (SAMPLE_BITS+1)'(rd_data);
   assign trial      = PROD_BITS'(div_ff) << step_ff;
   assign scaled     = SCALED_W'(lo_ff) * SCALED_W'(SCALE) + SCALED_W'(quo_ff);

   always_comb begin
      unique case (state_ff)
         ST_RD_LAST: rd_addr = cnt_m1_ff;
         ST_SRCH_RD: rd_addr = mid;
         ST_RD_LO:   rd_addr = lo_ff;
         ST_RD_HI:   rd_addr = hi_ff;
         default:    rd_addr = '0;
      endcase
   end

   always_comb begin
      num = '0;
      if (rd_data < tl_ff && s_ff <= tl_ff) begin
         num = tl_ff - s_ff;
         if ({1'b0, num} > diff) begin
            num = diff[SAMPLE_BITS-1:0];
         end
      end
   end

   tadc_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (accept && req_data.action == ACT_WRITE),
      .wr_addr (IDX_BITS'(req_data.entry_index)),
      .wr_data (req_data.entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      table_count_in = table_count_ff;
      zero_offset_in = zero_offset_ff;
      s_in           = s_ff;
      first_in       = first_ff;
      tl_in          = tl_ff;
      cnt_m1_in      = cnt_m1_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      quo_in         = quo_ff;
      step_in        = step_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = rsp_ff;

      if (csr_wr) begin
         unique case (paddr[2])
            REG_TABLE_COUNT: table_count_in = pwdata[CNT_BITS-1:0];
            REG_ZERO_OFFSET: zero_offset_in = pwdata[OFS_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.action == ACT_CONVERT) begin
               s_in = req_data.sample;
               priority if (table_count_ff == '0) begin
                  cnt_m1_in = '0;
               end else if (table_count_ff > CNT_BITS'(TABLE_DEPTH)) begin
                  cnt_m1_in = IDX_BITS'(TABLE_DEPTH - 1);
               end else begin
                  cnt_m1_in = IDX_BITS'(table_count_ff - CNT_BITS'(1));
               end
               state_in = ST_RD_FIRST;
            end
         end
         ST_RD_FIRST: state_in = ST_RD_LAST;
         ST_RD_LAST: begin
            first_in = rd_data;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            priority if (s_ff < rd_data) begin
               s_in = rd_data;
            end else if (s_ff > first_ff) begin
               s_in = first_ff;
            end
            left_in  = '0;
            right_in = (CNT_BITS+1)'(cnt_m1_ff);
            state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            priority if (rd_data == s_ff) begin
               lo_in    = mid;
               quo_in   = '0;
               state_in = ST_FINISH;
            end else if (s_ff < rd_data) begin
               if (next_left > right_ff) begin
                  lo_in = right_ff[IDX_BITS-1:0];
                  if (right_ff[IDX_BITS-1:0] == cnt_m1_ff) begin
                     quo_in   = '0;
                     state_in = ST_FINISH;
                  end else begin
                     hi_in    = right_ff[IDX_BITS-1:0] + IDX_BITS'(1);
                     state_in = ST_RD_LO;
                  end
               end else begin
                  left_in  = next_left;
                  state_in = ST_SRCH_RD;
               end
            end else begin
               if (next_right < left_ff) begin
                  if (left_ff == '0) begin
                     lo_in    = '0;
                     quo_in   = '0;
                     state_in = ST_FINISH;
                  end else begin
                     lo_in    = left_ff[IDX_BITS-1:0] - IDX_BITS'(1);
                     hi_in    = left_ff[IDX_BITS-1:0];
                     state_in = ST_RD_LO;
                  end
               end else begin
                  right_in = next_right;
                  state_in = ST_SRCH_RD;
               end
            end
         end
         ST_RD_LO: state_in = ST_RD_HI;
         ST_RD_HI: begin
            tl_in    = rd_data;
            state_in = ST_CALC;
         end
         ST_CALC: begin
            quo_in = '0;
            if (diff <= 0) begin
               state_in = ST_FINISH;
            end else begin
               rem_in   = PROD_BITS'(num) * PROD_BITS'(SCALE);
               div_in   = diff[SAMPLE_BITS-1:0];
               step_in  = STEP_BITS'(QUO_BITS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_ff >= trial) begin
               rem_in          = rem_ff - trial;
               quo_in[step_ff] = 1'b1;
            end
            if (step_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff - STEP_BITS'(1);
            end
         end
         ST_FINISH: begin
            rsp_in.temp_scaled = scaled;
            rsp_in.temp_centi  = CENTI_W'(scaled)
                                 - CENTI_W'(zero_offset_ff) * CENTI_W'(SCALE);
            rsp_strobe_in      = 1'b1;
            state_in           = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         table_count_ff <= CNT_BITS'(161);
         zero_offset_ff <= OFS_BITS'(40);
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         table_count_ff <= table_count_in;
         zero_offset_ff <= zero_offset_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      s_ff      <= s_in;
      first_ff  <= first_in;
      tl_ff     <= tl_in;
      cnt_m1_ff <= cnt_m1_in;
      left_ff   <= left_in;
      right_ff  <= right_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
